// ===== src/cmab_pkg.sv =====
// shared types and constants of the centered moving average blend filter
package cmab_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 22;
    localparam int HIST_AW    = 6;
    localparam int HIST_DEPTH = 64;
    localparam int HALF_W     = 5;
    localparam int GAIN_W     = 17;
    localparam int LEN_W      = 6;
    localparam int COEF_W     = 18;
    localparam int MUL_A_W    = 23;
    localparam int MUL_P_W    = MUL_A_W + COEF_W;
    localparam int AVG_W      = 40;
    localparam int ACC_W      = 58;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // largest lookahead and lookback
    localparam logic [HALF_W-1:0] MAX_HALF = 5'd31;

    // register reset values
    localparam logic [LEN_W-1:0]  RST_WINDOW_LENGTH = 6'd2;
    localparam logic [GAIN_W-1:0] RST_WINDOW_GAIN   = 17'd21845;
    localparam logic [GAIN_W-1:0] RST_STRENGTH      = 17'd65536;

    // register indexes, byte address divided by four
    typedef enum logic [1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_WINDOW_GAIN   = 2'd1,
        REG_STRENGTH      = 2'd2,
        REG_REMOVE_OFFSET = 2'd3
    } t_reg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_OLD,
        ST_SUB_OLD,
        ST_FL_RD,
        ST_FL_SUB,
        ST_MUL_AVG,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_X,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_sample;
        logic                       in_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       out_last;
    } t_out_beat;

endpackage

// ===== src/centered_moving_average_blend.sv =====
// top level of the centered moving average blend filter
//
// Input beats carry a signed 16-bit sample and a last flag; output beats carry
// the filtered sample and a last flag. Both channels use valid/ready. The
// filter lags by half = window_length/2 samples: the first half inputs of a
// stream give no output, each later input gives one, and the input flagged
// last gives its own result plus the remaining half results of the stream.
// The user must write registers over the APB port only while the block is
// idle; the block itself does not enforce this. An input that gives no
// result passes the accept, old-sample read and subtract steps; one that
// gives a result also takes four passes of one 23x18 multiplier (sum times
// gain, two halves of the average times strength, sample times one minus
// strength) and the output step. The single-port history memory serves one
// read per cycle. A flush result takes a flush read, a subtract, the four
// passes and the output step. The block takes no new input while it works.
// The result sits in an output register; a stalled receiver holds the block
// in its output step until the beat is taken.
// Reset clears the running sum, counters, history valid bits and registers;
// history entries never written read as zero.
module centered_moving_average_blend (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  cmab_pkg::t_in_beat                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output cmab_pkg::t_out_beat                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cmab_pkg::PADDR_W-1:0]        paddr,
    input  logic [cmab_pkg::PDATA_W-1:0]        pwdata,
    output logic [cmab_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    // configuration registers
    logic [cmab_pkg::LEN_W-1:0]  r_window_length;
    logic [cmab_pkg::GAIN_W-1:0] r_window_gain;
    logic [cmab_pkg::GAIN_W-1:0] r_strength;
    logic                        r_remove_offset;

    // control state
    cmab_pkg::t_state                   r_state, n_state;
    logic signed [cmab_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [cmab_pkg::HIST_AW-1:0]       r_wp, n_wp;
    logic [cmab_pkg::HIST_AW-1:0]       r_seen, n_seen;
    logic                               r_last, n_last;
    logic                               r_flush, n_flush;
    logic [cmab_pkg::HALF_W-1:0]        r_j, n_j;
    logic [cmab_pkg::HIST_DEPTH-1:0]    r_hist_vld;
    logic                               r_ovalid;

    // history memory and its read port
    logic [cmab_pkg::SAMPLE_W-1:0]      r_hist [cmab_pkg::HIST_DEPTH];
    logic [cmab_pkg::SAMPLE_W-1:0]      r_rd;
    logic                               r_rd_vld;
    logic signed [cmab_pkg::SAMPLE_W-1:0] rd_x;

    // datapath
    logic signed [cmab_pkg::AVG_W-1:0]   r_avg;
    logic signed [cmab_pkg::ACC_W-1:0]   r_acc;
    logic signed [cmab_pkg::SAMPLE_W-1:0] r_osample;
    logic                                r_olast;

    // control signals
    logic                          hist_we;
    logic                          rd_en;
    logic [cmab_pkg::HIST_AW-1:0]  rd_addr;
    logic                          out_load;
    logic                          finish;

    // derived counts
    logic [cmab_pkg::HALF_W-1:0]   wl_half;
    logic [cmab_pkg::HALF_W-1:0]   half;
    logic [cmab_pkg::HIST_AW-1:0]  half6;
    logic [cmab_pkg::HIST_AW-1:0]  half2;
    logic [cmab_pkg::HIST_AW:0]    seen_p1;
    logic [cmab_pkg::HALF_W-1:0]   flush_cnt;
    logic [cmab_pkg::HALF_W-1:0]   d;
    logic [cmab_pkg::HIST_AW:0]    n_minus_d;
    logic                          out_last_val;

    // multiplier and rounding
    logic signed [cmab_pkg::COEF_W-1:0]  coef_s;
    logic signed [cmab_pkg::COEF_W-1:0]  coef_w;
    logic signed [cmab_pkg::MUL_A_W-1:0] mul_a;
    logic signed [cmab_pkg::COEF_W-1:0]  mul_b;
    logic signed [cmab_pkg::MUL_P_W-1:0] mul_p;
    logic signed [19:0]                  avg_hi;
    logic signed [cmab_pkg::ACC_W-1:0]   acc_rnd;
    logic signed [25:0]                  acc_q;
    logic signed [cmab_pkg::SAMPLE_W-1:0] sat_q;

    // apb register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= cmab_pkg::RST_WINDOW_LENGTH;
            r_window_gain   <= cmab_pkg::RST_WINDOW_GAIN;
            r_strength      <= cmab_pkg::RST_STRENGTH;
            r_remove_offset <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (cmab_pkg::t_reg_idx'(paddr[3:2]))
                cmab_pkg::REG_WINDOW_LENGTH: r_window_length <= pwdata[cmab_pkg::LEN_W-1:0];
                cmab_pkg::REG_WINDOW_GAIN:   r_window_gain   <= pwdata[cmab_pkg::GAIN_W-1:0];
                cmab_pkg::REG_STRENGTH:      r_strength      <= pwdata[cmab_pkg::GAIN_W-1:0];
                cmab_pkg::REG_REMOVE_OFFSET: r_remove_offset <= pwdata[0];
                default: ;
            endcase
        end
    end

    // apb register reads
    always_comb begin
        case (cmab_pkg::t_reg_idx'(paddr[3:2]))
            cmab_pkg::REG_WINDOW_LENGTH: prdata = 32'(r_window_length);
            cmab_pkg::REG_WINDOW_GAIN:   prdata = 32'(r_window_gain);
            cmab_pkg::REG_STRENGTH:      prdata = 32'(r_strength);
            cmab_pkg::REG_REMOVE_OFFSET: prdata = 32'(r_remove_offset);
            default:                     prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // window geometry
    assign wl_half   = r_window_length[cmab_pkg::LEN_W-1:1];
    assign half      = (wl_half > cmab_pkg::MAX_HALF) ? cmab_pkg::MAX_HALF : wl_half;
    assign half6     = {1'b0, half};
    assign half2     = {half, 1'b0};
    assign seen_p1   = {1'b0, r_seen} + 7'd1;
    assign flush_cnt = (seen_p1 < {2'b00, half}) ? seen_p1[cmab_pkg::HALF_W-1:0] : half;
    assign d         = r_j - 5'd1;
    assign n_minus_d = {1'b0, r_seen} - {2'b00, d};
    assign out_last_val = r_last && (r_flush ? (r_j == 5'd1) : (flush_cnt == 5'd0));

    // unwritten history entries read as zero
    assign rd_x = r_rd_vld ? signed'(r_rd) : '0;

    // state register and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= cmab_pkg::ST_IDLE;
            r_sum      <= '0;
            r_wp       <= '0;
            r_seen     <= '0;
            r_last     <= 1'b0;
            r_flush    <= 1'b0;
            r_j        <= '0;
            r_hist_vld <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_wp    <= n_wp;
            r_seen  <= n_seen;
            r_last  <= n_last;
            r_flush <= n_flush;
            r_j     <= n_j;
            if (hist_we) begin
                r_hist_vld[r_wp] <= 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // sequencer: next state and control
    always_comb begin
        n_state  = r_state;
        n_sum    = r_sum;
        n_wp     = r_wp;
        n_seen   = r_seen;
        n_last   = r_last;
        n_flush  = r_flush;
        n_j      = r_j;
        hist_we  = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_wp;
        out_load = 1'b0;
        finish   = 1'b0;
        case (r_state)
            cmab_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    hist_we = 1'b1;
                    n_sum   = r_sum + cmab_pkg::SUM_W'(i_in_data.in_sample);
                    n_last  = i_in_data.in_last;
                    n_flush = 1'b0;
                    n_state = cmab_pkg::ST_RD_OLD;
                end
            end
            // fetch the sample that leaves the window
            cmab_pkg::ST_RD_OLD: begin
                rd_en   = 1'b1;
                rd_addr = r_wp - half2;
                n_state = cmab_pkg::ST_SUB_OLD;
            end
            cmab_pkg::ST_SUB_OLD: begin
                if (r_seen >= half2) begin
                    n_sum = r_sum - cmab_pkg::SUM_W'(rd_x);
                end
                if (r_seen >= half6) begin
                    rd_en   = 1'b1;
                    rd_addr = r_wp - half6;
                    n_state = cmab_pkg::ST_MUL_AVG;
                end else if (r_last) begin
                    n_flush = 1'b1;
                    n_j     = flush_cnt;
                    n_state = cmab_pkg::ST_FL_RD;
                end else begin
                    finish = 1'b1;
                end
            end
            // flush: fetch the sample that leaves the window
            cmab_pkg::ST_FL_RD: begin
                rd_en   = 1'b1;
                rd_addr = r_wp - {1'b0, d} - half6;
                n_state = cmab_pkg::ST_FL_SUB;
            end
            cmab_pkg::ST_FL_SUB: begin
                if (n_minus_d >= {2'b00, half}) begin
                    n_sum = r_sum - cmab_pkg::SUM_W'(rd_x);
                end
                rd_en   = 1'b1;
                rd_addr = r_wp - {1'b0, d};
                n_state = cmab_pkg::ST_MUL_AVG;
            end
            cmab_pkg::ST_MUL_AVG: n_state = cmab_pkg::ST_MUL_LO;
            cmab_pkg::ST_MUL_LO:  n_state = cmab_pkg::ST_MUL_HI;
            cmab_pkg::ST_MUL_HI:  n_state = cmab_pkg::ST_MUL_X;
            cmab_pkg::ST_MUL_X:   n_state = cmab_pkg::ST_OUT;
            // hand the result to the output register
            cmab_pkg::ST_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    out_load = 1'b1;
                    if (r_flush) begin
                        if (r_j == 5'd1) begin
                            finish = 1'b1;
                        end else begin
                            n_j     = r_j - 5'd1;
                            n_state = cmab_pkg::ST_FL_RD;
                        end
                    end else if (r_last && (flush_cnt != 5'd0)) begin
                        n_flush = 1'b1;
                        n_j     = flush_cnt;
                        n_state = cmab_pkg::ST_FL_RD;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            default: n_state = cmab_pkg::ST_IDLE;
        endcase
        // end of item: advance, or restart the stream after the last beat
        if (finish) begin
            n_state = cmab_pkg::ST_IDLE;
            if (r_last) begin
                n_sum  = '0;
                n_seen = '0;
                n_wp   = '0;
            end else begin
                n_wp   = r_wp + 6'd1;
                n_seen = (r_seen == 6'd63) ? r_seen : r_seen + 6'd1;
            end
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[r_wp] <= i_in_data.in_sample;
        end
        if (rd_en) begin
            r_rd     <= r_hist[rd_addr];
            r_rd_vld <= r_hist_vld[rd_addr];
        end
    end

    // coefficients; offset mode is the blend with weights one and minus one
    assign coef_s = r_remove_offset ? -18'sd65536 : signed'({1'b0, r_strength});
    assign coef_w = r_remove_offset ? 18'sd65536
                                    : 18'sd65536 - signed'({1'b0, r_strength});
    assign avg_hi = signed'(r_avg[cmab_pkg::AVG_W-1:20]);

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            cmab_pkg::ST_MUL_AVG: begin
                mul_a = cmab_pkg::MUL_A_W'(r_sum);
                mul_b = signed'({1'b0, r_window_gain});
            end
            cmab_pkg::ST_MUL_LO: begin
                mul_a = signed'({3'b000, r_avg[19:0]});
                mul_b = coef_s;
            end
            cmab_pkg::ST_MUL_HI: begin
                mul_a = cmab_pkg::MUL_A_W'(avg_hi);
                mul_b = coef_s;
            end
            default: begin
                mul_a = cmab_pkg::MUL_A_W'(rd_x);
                mul_b = coef_w;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // round to nearest, ties up, then saturate
    assign acc_rnd = r_acc + 58'sd2147483648;
    assign acc_q   = signed'(acc_rnd[cmab_pkg::ACC_W-1:32]);
    always_comb begin
        if (acc_q > 26'sd32767) begin
            sat_q = 16'sh7fff;
        end else if (acc_q < -26'sd32768) begin
            sat_q = -16'sd32768;
        end else begin
            sat_q = acc_q[cmab_pkg::SAMPLE_W-1:0];
        end
    end

    // multiply-accumulate and output register
    always_ff @(posedge i_clk) begin
        case (r_state)
            cmab_pkg::ST_MUL_AVG: r_avg <= mul_p[cmab_pkg::AVG_W-1:0];
            cmab_pkg::ST_MUL_LO:  r_acc <= cmab_pkg::ACC_W'(mul_p);
            cmab_pkg::ST_MUL_HI:  r_acc <= r_acc + (cmab_pkg::ACC_W'(mul_p) <<< 20);
            cmab_pkg::ST_MUL_X:   r_acc <= r_acc + (cmab_pkg::ACC_W'(mul_p) <<< 16);
            default: ;
        endcase
        if (out_load) begin
            r_osample <= sat_q;
            r_olast   <= out_last_val;
        end
    end

    assign o_in_ready            = (r_state == cmab_pkg::ST_IDLE);
    assign o_out_valid           = r_ovalid;
    assign o_out_data.out_sample = r_osample;
    assign o_out_data.out_last   = r_olast;

endmodule
